// File: src/rwl_pkg.sv
`default_nettype none

package rwl_pkg;

    // Queue depth and the widths that follow from it.
    localparam int MAX_THREADS = 16;
    localparam int HW          = (MAX_THREADS > 1) ? $clog2(MAX_THREADS) : 1;
    localparam int CW          = $clog2(MAX_THREADS + 1);
    localparam int SW          = $clog2(2 * MAX_THREADS);

    localparam int TIDW = 4;
    localparam int RDW  = 5;
    localparam logic [RDW-1:0] READER_MAX = 5'd31;

    // Request codes.
    typedef enum logic [1:0] {
        RQ_START_READ  = 2'd0,
        RQ_END_READ    = 2'd1,
        RQ_START_WRITE = 2'd2,
        RQ_END_WRITE   = 2'd3
    } t_req;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_RELEASED = 3'd0,
        ST_READ     = 3'd1,
        ST_WRITE    = 3'd2,
        ST_QUEUED   = 3'd3,
        ST_ERROR    = 3'd4
    } t_status;

    // Datapath operations, one per microinstruction.
    typedef enum logic [3:0] {
        OP_NONE,
        OP_FETCH,
        OP_RD_INC,
        OP_RD_DEC,
        OP_WB_SET,
        OP_WB_CLR,
        OP_RQ_PUSH,
        OP_WQ_PUSH,
        OP_RQ_POP,
        OP_WQ_POP
    } t_op;

    // Source of a result: requester, head of either queue, or the final flush.
    typedef enum logic [2:0] {
        E_NONE,
        E_TID,
        E_RQ_HEAD,
        E_WQ_HEAD,
        E_FLUSH
    } t_emit;

    // Jump conditions. A true condition loads the target (dispatch loads the routine
    // entry for the request code instead), otherwise the step counter advances by one.
    typedef enum logic [3:0] {
        C_ALWAYS,
        C_DISPATCH,
        C_WBUSY,
        C_NOT_WBUSY,
        C_RD_FULL,
        C_RD_ZERO,
        C_RD_OR_WB,
        C_RQ_FULL,
        C_WQ_FULL,
        C_RQ_EMPTY,
        C_NO_RD_WAKE,
        C_NO_WR_WAKE
    } t_cond;

    localparam int PCW = 5;

    // Microprogram addresses.
    localparam logic [PCW-1:0] A_FETCH = 5'd0;
    localparam logic [PCW-1:0] A_SR0   = 5'd1;
    localparam logic [PCW-1:0] A_SR1   = 5'd2;
    localparam logic [PCW-1:0] A_SR2   = 5'd3;
    localparam logic [PCW-1:0] A_SRQ0  = 5'd4;
    localparam logic [PCW-1:0] A_SRQ1  = 5'd5;
    localparam logic [PCW-1:0] A_ERR   = 5'd6;
    localparam logic [PCW-1:0] A_WRD0  = 5'd7;
    localparam logic [PCW-1:0] A_WRD1  = 5'd8;
    localparam logic [PCW-1:0] A_FLUSH = 5'd9;
    localparam logic [PCW-1:0] A_WWR0  = 5'd10;
    localparam logic [PCW-1:0] A_WWR1  = 5'd11;
    localparam logic [PCW-1:0] A_ER0   = 5'd12;
    localparam logic [PCW-1:0] A_ER1   = 5'd13;
    localparam logic [PCW-1:0] A_SW0   = 5'd14;
    localparam logic [PCW-1:0] A_SW1   = 5'd15;
    localparam logic [PCW-1:0] A_SWQ0  = 5'd16;
    localparam logic [PCW-1:0] A_SWQ1  = 5'd17;
    localparam logic [PCW-1:0] A_EW0   = 5'd18;
    localparam logic [PCW-1:0] A_EW1   = 5'd19;
    localparam logic [PCW-1:0] A_EW2   = 5'd20;

    typedef struct packed {
        t_op            op;
        t_emit          emit;
        t_status        st;
        t_cond          cond;
        logic [PCW-1:0] target;
    } t_uword;

    // Step control from the sequencer to the datapath.
    typedef struct packed {
        logic   fire;
        t_uword uw;
    } t_ctl;

    // Condition flags from the datapath to the sequencer.
    typedef struct packed {
        logic wbusy;
        logic rd_full;
        logic rd_zero;
        logic rq_full;
        logic wq_full;
        logic rq_empty;
        logic rd_wake;
        logic wr_wake;
        logic out_free;
    } t_flags;

    function automatic t_uword mk(t_op op, t_emit emit, t_status st, t_cond cond,
                                  logic [PCW-1:0] target);
        t_uword w;
        w.op     = op;
        w.emit   = emit;
        w.st     = st;
        w.cond   = cond;
        w.target = target;
        return w;
    endfunction

    // The control store.
    function automatic t_uword rwl_ucode(logic [PCW-1:0] addr);
        t_uword w;
        unique case (addr)
            A_FETCH: w = mk(OP_FETCH,   E_NONE,    ST_RELEASED, C_DISPATCH,   A_FETCH);
            A_SR0:   w = mk(OP_NONE,    E_NONE,    ST_RELEASED, C_WBUSY,      A_SRQ0);
            A_SR1:   w = mk(OP_NONE,    E_NONE,    ST_RELEASED, C_RD_FULL,    A_ERR);
            A_SR2:   w = mk(OP_RD_INC,  E_TID,     ST_READ,     C_ALWAYS,     A_WRD0);
            A_SRQ0:  w = mk(OP_NONE,    E_NONE,    ST_RELEASED, C_RQ_FULL,    A_ERR);
            A_SRQ1:  w = mk(OP_RQ_PUSH, E_TID,     ST_QUEUED,   C_ALWAYS,     A_FLUSH);
            A_ERR:   w = mk(OP_NONE,    E_TID,     ST_ERROR,    C_ALWAYS,     A_FLUSH);
            A_WRD0:  w = mk(OP_NONE,    E_NONE,    ST_RELEASED, C_NO_RD_WAKE, A_FLUSH);
            A_WRD1:  w = mk(OP_RQ_POP,  E_RQ_HEAD, ST_READ,     C_ALWAYS,     A_WRD0);
            A_FLUSH: w = mk(OP_NONE,    E_FLUSH,   ST_RELEASED, C_ALWAYS,     A_FETCH);
            A_WWR0:  w = mk(OP_NONE,    E_NONE,    ST_RELEASED, C_NO_WR_WAKE, A_FLUSH);
            A_WWR1:  w = mk(OP_WQ_POP,  E_WQ_HEAD, ST_WRITE,    C_ALWAYS,     A_FLUSH);
            A_ER0:   w = mk(OP_NONE,    E_NONE,    ST_RELEASED, C_RD_ZERO,    A_ERR);
            A_ER1:   w = mk(OP_RD_DEC,  E_TID,     ST_RELEASED, C_ALWAYS,     A_WWR0);
            A_SW0:   w = mk(OP_NONE,    E_NONE,    ST_RELEASED, C_RD_OR_WB,   A_SWQ0);
            A_SW1:   w = mk(OP_WB_SET,  E_TID,     ST_WRITE,    C_ALWAYS,     A_FLUSH);
            A_SWQ0:  w = mk(OP_NONE,    E_NONE,    ST_RELEASED, C_WQ_FULL,    A_ERR);
            A_SWQ1:  w = mk(OP_WQ_PUSH, E_TID,     ST_QUEUED,   C_ALWAYS,     A_FLUSH);
            A_EW0:   w = mk(OP_NONE,    E_NONE,    ST_RELEASED, C_NOT_WBUSY,  A_ERR);
            A_EW1:   w = mk(OP_WB_CLR,  E_TID,     ST_RELEASED, C_RQ_EMPTY,   A_WWR0);
            A_EW2:   w = mk(OP_NONE,    E_NONE,    ST_RELEASED, C_ALWAYS,     A_WRD0);
            default: w = mk(OP_NONE,    E_NONE,    ST_RELEASED, C_ALWAYS,     A_FETCH);
        endcase
        return w;
    endfunction

    // Entry point of the routine for each request code.
    function automatic logic [PCW-1:0] rwl_dispatch(t_req req);
        logic [PCW-1:0] a;
        unique case (req)
            RQ_START_READ:  a = A_SR0;
            RQ_END_READ:    a = A_ER0;
            RQ_START_WRITE: a = A_SW0;
            RQ_END_WRITE:   a = A_EW0;
            default:        a = A_FETCH;
        endcase
        return a;
    endfunction

endpackage

`default_nettype wire

// File: src/rwl_if.sv
`default_nettype none

interface rwl_req_if import rwl_pkg::*;;
    logic            valid;
    logic            ready;
    logic [1:0]      req_type;
    logic [TIDW-1:0] thread_id;

    modport source (output valid, output req_type, output thread_id, input ready);
    modport sink   (input valid, input req_type, input thread_id, output ready);
endinterface

interface rwl_res_if import rwl_pkg::*;;
    logic            valid;
    logic            ready;
    logic [TIDW-1:0] who;
    logic [2:0]      status;
    logic            last;

    modport source (output valid, output who, output status, output last, input ready);
    modport sink   (input valid, input who, input status, input last, output ready);
endinterface

`default_nettype wire

// File: src/rwl_useq.sv
`default_nettype none

module rwl_useq import rwl_pkg::*; (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_req_valid,
    input  wire logic [1:0] i_req_type,
    input  wire t_flags     i_flags,
    output logic            o_req_ready,
    output t_ctl            o_ctl
);

    logic [PCW-1:0] r_pc;
    logic [PCW-1:0] n_pc;
    t_uword         uw;
    logic           hold;
    logic           taken;

    assign uw = rwl_ucode(r_pc);

    // A step waits for a request on fetch, and for a free output slot when it
    // produces a result.
    assign hold = ((uw.op == OP_FETCH) && !i_req_valid)
               || ((uw.emit != E_NONE) && !i_flags.out_free);

    assign o_req_ready = (uw.op == OP_FETCH) && i_rst_n;
    assign o_ctl.fire  = !hold;
    assign o_ctl.uw    = uw;

    always_comb begin
        unique case (uw.cond)
            C_ALWAYS:     taken = 1'b1;
            C_DISPATCH:   taken = 1'b1;
            C_WBUSY:      taken = i_flags.wbusy;
            C_NOT_WBUSY:  taken = !i_flags.wbusy;
            C_RD_FULL:    taken = i_flags.rd_full;
            C_RD_ZERO:    taken = i_flags.rd_zero;
            C_RD_OR_WB:   taken = !i_flags.rd_zero || i_flags.wbusy;
            C_RQ_FULL:    taken = i_flags.rq_full;
            C_WQ_FULL:    taken = i_flags.wq_full;
            C_RQ_EMPTY:   taken = i_flags.rq_empty;
            C_NO_RD_WAKE: taken = !i_flags.rd_wake;
            C_NO_WR_WAKE: taken = !i_flags.wr_wake;
            default:      taken = 1'b1;
        endcase
    end

    always_comb begin
        if (hold) begin
            n_pc = r_pc;
        end else if (uw.cond == C_DISPATCH) begin
            n_pc = rwl_dispatch(t_req'(i_req_type));
        end else if (taken) begin
            n_pc = uw.target;
        end else begin
            n_pc = r_pc + PCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pc <= A_FETCH;
        end else begin
            r_pc <= n_pc;
        end
    end

endmodule

`default_nettype wire

// File: src/rwl_dpath.sv
`default_nettype none

module rwl_dpath import rwl_pkg::*; (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire t_ctl            i_ctl,
    input  wire logic [TIDW-1:0] i_thread_id,
    input  wire logic            i_out_ready,
    output t_flags               o_flags,
    output logic                 o_out_valid,
    output logic [TIDW-1:0]      o_out_who,
    output logic [2:0]           o_out_status,
    output logic                 o_out_last
);

    logic [RDW-1:0]  r_active;
    logic            r_wbusy;
    logic [TIDW-1:0] r_tid;

    logic [TIDW-1:0] r_rq_ids [MAX_THREADS];
    logic [HW-1:0]   r_rq_head;
    logic [CW-1:0]   r_rq_cnt;
    logic [TIDW-1:0] r_wq_ids [MAX_THREADS];
    logic [HW-1:0]   r_wq_head;
    logic [CW-1:0]   r_wq_cnt;

    // One result is held back until the next one (or the end of the routine)
    // shows whether it is the last.
    logic            r_pend_vld;
    logic [TIDW-1:0] r_pend_who;
    t_status         r_pend_st;

    logic            r_out_vld;
    logic [TIDW-1:0] r_out_who;
    t_status         r_out_st;
    logic            r_out_last;

    logic            out_free;
    logic            rd_full;
    logic            rd_zero;
    logic [TIDW-1:0] new_who;
    logic            do_emit;
    logic            do_flush;
    logic            do_load;

    function automatic logic [HW-1:0] tail_slot(logic [HW-1:0] head, logic [CW-1:0] cnt);
        logic [SW:0] sum;
        sum = (SW+1)'(head) + (SW+1)'(cnt);
        if (sum >= (SW+1)'(MAX_THREADS)) begin
            sum = sum - (SW+1)'(MAX_THREADS);
        end
        return sum[HW-1:0];
    endfunction

    function automatic logic [HW-1:0] head_next(logic [HW-1:0] head);
        return (head == HW'(MAX_THREADS - 1)) ? '0 : head + HW'(1);
    endfunction

    assign out_free = !r_out_vld || i_out_ready;
    assign rd_full  = (r_active == READER_MAX);
    assign rd_zero  = (r_active == '0);

    assign o_flags.wbusy    = r_wbusy;
    assign o_flags.rd_full  = rd_full;
    assign o_flags.rd_zero  = rd_zero;
    assign o_flags.rq_full  = (r_rq_cnt == CW'(MAX_THREADS));
    assign o_flags.wq_full  = (r_wq_cnt == CW'(MAX_THREADS));
    assign o_flags.rq_empty = (r_rq_cnt == '0);
    assign o_flags.rd_wake  = (r_rq_cnt != '0) && !rd_full;
    assign o_flags.wr_wake  = (r_wq_cnt != '0) && rd_zero && !r_wbusy;
    assign o_flags.out_free = out_free;

    always_comb begin
        unique case (i_ctl.uw.emit)
            E_RQ_HEAD: new_who = r_rq_ids[r_rq_head];
            E_WQ_HEAD: new_who = r_wq_ids[r_wq_head];
            default:   new_who = r_tid;
        endcase
    end

    assign do_flush = i_ctl.fire && (i_ctl.uw.emit == E_FLUSH);
    assign do_emit  = i_ctl.fire && (i_ctl.uw.emit != E_NONE) && !do_flush;
    assign do_load  = do_flush || (do_emit && r_pend_vld);

    always_ff @(posedge i_clk) begin
        if (i_ctl.fire && (i_ctl.uw.op == OP_RQ_PUSH)) begin
            r_rq_ids[tail_slot(r_rq_head, r_rq_cnt)] <= r_tid;
        end
        if (i_ctl.fire && (i_ctl.uw.op == OP_WQ_PUSH)) begin
            r_wq_ids[tail_slot(r_wq_head, r_wq_cnt)] <= r_tid;
        end
        if (i_ctl.fire && (i_ctl.uw.op == OP_FETCH)) begin
            r_tid <= i_thread_id;
        end
        if (do_emit) begin
            r_pend_who <= new_who;
            r_pend_st  <= i_ctl.uw.st;
        end
        if (do_load) begin
            r_out_who  <= r_pend_who;
            r_out_st   <= r_pend_st;
            r_out_last <= do_flush;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active   <= '0;
            r_wbusy    <= 1'b0;
            r_rq_head  <= '0;
            r_rq_cnt   <= '0;
            r_wq_head  <= '0;
            r_wq_cnt   <= '0;
            r_pend_vld <= 1'b0;
            r_out_vld  <= 1'b0;
        end else begin
            if (do_load) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
            if (do_emit) begin
                r_pend_vld <= 1'b1;
            end else if (do_flush) begin
                r_pend_vld <= 1'b0;
            end
            if (i_ctl.fire) begin
                unique case (i_ctl.uw.op)
                    OP_RD_INC:  r_active <= r_active + RDW'(1);
                    OP_RD_DEC:  r_active <= r_active - RDW'(1);
                    OP_WB_SET:  r_wbusy  <= 1'b1;
                    OP_WB_CLR:  r_wbusy  <= 1'b0;
                    OP_RQ_PUSH: r_rq_cnt <= r_rq_cnt + CW'(1);
                    OP_WQ_PUSH: r_wq_cnt <= r_wq_cnt + CW'(1);
                    OP_RQ_POP: begin
                        r_rq_head <= head_next(r_rq_head);
                        r_rq_cnt  <= r_rq_cnt - CW'(1);
                        r_active  <= r_active + RDW'(1);
                    end
                    OP_WQ_POP: begin
                        r_wq_head <= head_next(r_wq_head);
                        r_wq_cnt  <= r_wq_cnt - CW'(1);
                        r_wbusy   <= 1'b1;
                    end
                    default: begin
                    end
                endcase
            end
        end
    end

    assign o_out_valid  = r_out_vld;
    assign o_out_who    = r_out_who;
    assign o_out_status = r_out_st;
    assign o_out_last   = r_out_last;

endmodule

`default_nettype wire

// File: src/rw_lock_arbiter_top.sv
// Channel | Direction | Payload                          | Handshake
// i_req   | in        | req_type[1:0], thread_id[3:0]    | valid / ready
// o_res   | out       | who[3:0], status[2:0], last      | valid / ready
//
// Each request transaction runs a short microcode routine: one step per cycle
// unless the step waits for a request or a free output slot. A request passes
// through fetch, tests, one grant step and a final flush, plus a test and a pop
// step for every queued reader woken in a chain, one control word per step.
// Reset is synchronous and active low; it empties both wait queues, clears the
// reader count and the writer flag, and parks the sequencer at fetch.
// A step that produces a result waits while the output register is full and
// not being taken; no new request is taken until every result is on its way.

`default_nettype none

module rw_lock_arbiter_top import rwl_pkg::*; (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    rwl_req_if.sink    i_req,
    rwl_res_if.source  o_res
);

    // The sequencer reads the control store and evaluates the jump condition
    // chosen by the current control word; the datapath holds the lock state,
    // the two circular wait queues and the result registers.
    t_ctl   ctl;
    t_flags flags;

    rwl_useq u_useq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req_valid (i_req.valid),
        .i_req_type  (i_req.req_type),
        .i_flags     (flags),
        .o_req_ready (i_req.ready),
        .o_ctl       (ctl)
    );

    // The thread id is captured on the fetch step; the request code only
    // steers the dispatch jump, so it needs no register of its own.
    rwl_dpath u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ctl        (ctl),
        .i_thread_id  (i_req.thread_id),
        .i_out_ready  (o_res.ready),
        .o_flags      (flags),
        .o_out_valid  (o_res.valid),
        .o_out_who    (o_res.who),
        .o_out_status (o_res.status),
        .o_out_last   (o_res.last)
    );

endmodule

`default_nettype wire

// File: src/rwl_checker.sv
`default_nettype none

module rwl_checker import rwl_pkg::*; (
    input wire logic            i_clk,
    input wire logic            i_rst_n,
    input wire logic            i_req_valid,
    input wire logic            i_req_ready,
    input wire logic            i_res_valid,
    input wire logic            i_res_ready,
    input wire logic [TIDW-1:0] i_res_who,
    input wire logic [2:0]      i_res_status,
    input wire logic            i_res_last
);

    // Number of request transactions whose last result has not yet been taken.
    // A new request may be taken while the last result of the previous one
    // still waits in the output register, so this reaches two at most.
    logic [1:0] r_open;
    logic       req_acc;
    logic       last_acc;

    assign req_acc  = i_req_valid && i_req_ready;
    assign last_acc = i_res_valid && i_res_ready && i_res_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 2'd0;
        end else if (req_acc && !last_acc) begin
            r_open <= r_open + 2'd1;
        end else if (!req_acc && last_acc) begin
            r_open <= r_open - 2'd1;
        end
    end

    a_res_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && !i_res_ready |=> i_res_valid && $stable(i_res_who)
            && $stable(i_res_status) && $stable(i_res_last))
        else $error("result changed while stalled");

    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req_valid && i_req_ready |-> (r_open == 2'd0)
            || ((r_open == 2'd1) && i_res_valid && i_res_last))
        else $error("request taken before previous results were produced");

    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid |-> (r_open != 2'd0))
        else $error("result with no request outstanding");

    a_sole_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_res_valid && (i_res_status == ST_QUEUED || i_res_status == ST_ERROR)
            |-> i_res_last)
        else $error("queued or error result not marked last");

endmodule

bind rw_lock_arbiter_top rwl_checker u_rwl_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_res_valid  (o_res.valid),
    .i_res_ready  (o_res.ready),
    .i_res_who    (o_res.who),
    .i_res_status (o_res.status),
    .i_res_last   (o_res.last)
);

`default_nettype wire

// File: dv/rwl_reply_checker.sv
`default_nettype none

module rwl_reply_checker import rwl_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    rwl_req_if        i_req_mon,
    rwl_res_if        i_res_mon,
    output int        o_errors,
    output int        o_pending,
    output int        o_checked
);

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [TIDW-1:0] who;
        t_status         status;
        logic            last;
    } t_reply;

    // Lock state as the predictor sees it.
    int              readers_active;
    logic            writer_held;
    logic [TIDW-1:0] rd_waiters[$];
    logic [TIDW-1:0] wr_waiters[$];

    // Replies for the request in hand, then every reply still owed by the block.
    t_reply wake_batch[$];
    t_reply owed_replies[$];

    int mismatches;
    int checked;

    assign o_errors  = mismatches;
    assign o_checked = checked;

    task automatic report_mismatch(string msg);
        mismatches++;
        $display("%0t ns: %s", $time, msg);
    endtask

    function automatic void note(logic [TIDW-1:0] who, t_status st);
        t_reply r;
        r.who    = who;
        r.status = st;
        r.last   = 1'b0;
        wake_batch.push_back(r);
    endfunction

    function automatic void wake_readers();
        while (rd_waiters.size() > 0 && readers_active < int'(READER_MAX)) begin
            readers_active++;
            note(rd_waiters.pop_front(), ST_READ);
        end
    endfunction

    function automatic void wake_writer();
        if (wr_waiters.size() > 0 && readers_active == 0 && !writer_held) begin
            writer_held = 1'b1;
            note(wr_waiters.pop_front(), ST_WRITE);
        end
    endfunction

    task automatic apply_request(t_req rq, logic [TIDW-1:0] tid);
        t_reply r;
        wake_batch.delete();
        case (rq)
            RQ_START_READ: begin
                if (writer_held) begin
                    if (rd_waiters.size() >= MAX_THREADS) begin
                        note(tid, ST_ERROR);
                    end else begin
                        rd_waiters.push_back(tid);
                        note(tid, ST_QUEUED);
                    end
                end else if (readers_active >= int'(READER_MAX)) begin
                    note(tid, ST_ERROR);
                end else begin
                    readers_active++;
                    note(tid, ST_READ);
                    wake_readers();
                end
            end
            RQ_END_READ: begin
                if (readers_active == 0) begin
                    note(tid, ST_ERROR);
                end else begin
                    readers_active--;
                    note(tid, ST_RELEASED);
                    if (readers_active == 0) wake_writer();
                end
            end
            RQ_START_WRITE: begin
                if (readers_active > 0 || writer_held) begin
                    if (wr_waiters.size() >= MAX_THREADS) begin
                        note(tid, ST_ERROR);
                    end else begin
                        wr_waiters.push_back(tid);
                        note(tid, ST_QUEUED);
                    end
                end else begin
                    writer_held = 1'b1;
                    note(tid, ST_WRITE);
                end
            end
            default: begin
                if (!writer_held) begin
                    note(tid, ST_ERROR);
                end else begin
                    writer_held = 1'b0;
                    note(tid, ST_RELEASED);
                    if (rd_waiters.size() > 0) wake_readers();
                    else wake_writer();
                end
            end
        endcase
        foreach (wake_batch[i]) begin
            r      = wake_batch[i];
            r.last = (i == wake_batch.size() - 1);
            owed_replies.push_back(r);
        end
    endtask

    always @(posedge i_clk) begin
        t_reply got;
        t_reply want;
        if (!i_rst_n) begin
            readers_active = 0;
            writer_held    = 1'b0;
            rd_waiters.delete();
            wr_waiters.delete();
            owed_replies.delete();
        end else begin
            if (i_req_mon.valid && i_req_mon.ready)
                apply_request(t_req'(i_req_mon.req_type), i_req_mon.thread_id);
            if (i_res_mon.valid && i_res_mon.ready) begin
                checked++;
                got.who    = i_res_mon.who;
                got.status = t_status'(i_res_mon.status);
                got.last   = i_res_mon.last;
                if (owed_replies.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with nothing owed", checked));
                end else begin
                    want = owed_replies.pop_front();
                    if (got.who !== want.who)
                        report_mismatch($sformatf("result %0d: who expected %0d, got %0d",
                                                  checked, want.who, got.who));
                    if (got.status !== want.status)
                        report_mismatch($sformatf("result %0d: status expected %0d, got %0d",
                                                  checked, want.status, got.status));
                    if (got.last !== want.last)
                        report_mismatch($sformatf("result %0d: last expected %0b, got %0b",
                                                  checked, want.last, got.last));
                end
            end
        end
        o_pending <= owed_replies.size();
    end

endmodule

`default_nettype wire

// File: dv/rw_lock_arbiter_top_test.sv
`default_nettype none

// Stimulus and verdict for the readers-writer lock arbiter. The checker beside
// the block predicts every result transaction and compares it; this module only
// produces request transactions, paces both channels and reports the outcome.
module rw_lock_arbiter_top_test import rwl_pkg::*;;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int RUN_ITEMS   = 350;
    // Quiet cycles after the drain, enough for a request with a full chain of
    // woken readers to finish, so that the block has truly gone idle.
    localparam int SETTLE      = 40;
    // Far beyond the slowest correct run, even with every stall at its worst.
    localparam int CYCLE_LIMIT = 500000;

    logic i_clk;
    logic i_rst_n;

    rwl_req_if req_ch ();
    rwl_res_if res_ch ();

    int pace;      // pacing phase: 0 none, 1 sender idles, 2 receiver stalls, 3 both
    int sent;
    int cycles;
    int errors;
    int pending;
    int checked;

    rw_lock_arbiter_top DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_res   (res_ch.source)
    );

    rwl_reply_checker u_checker (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req_mon (req_ch),
        .i_res_mon (res_ch),
        .o_errors  (errors),
        .o_pending (pending),
        .o_checked (checked)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog: a hung handshake or a result that never comes ends the run here.
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Mismatches found");
            $finish;
        end
    end

    // The receiver holds ready low with a chance of 56 or 22 in a hundred in the
    // receiver-stall and both phases, and keeps it high otherwise. The phase only
    // ever changes by a nonblocking update, so this block always sees a settled value.
    always @(posedge i_clk) begin
        res_ch.ready <= ($urandom_range(99) >= ((pace == 2) ? 56 : (pace == 3) ? 22 : 0));
    end

    function automatic logic [TIDW-1:0] any_tid();
        return TIDW'($urandom_range(15));
    endfunction

    // Offers one request transaction and returns at the edge where it is taken.
    // Valid is left high on return; the next call either keeps it high for the
    // following item or lowers it for an idle gap, never both in one step.
    task automatic send_request(t_req rq, logic [TIDW-1:0] tid);
        int gap;
        gap = (pace == 1) ? 56 : (pace == 3) ? 22 : 0;
        while ($urandom_range(99) < gap) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid     <= 1'b1;
        req_ch.req_type  <= rq;
        req_ch.thread_id <= tid;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        sent++;
        // Move through the four pacing phases every forty transactions.
        pace <= (sent / 40) % 4;
    endtask

    // Holds the sender back until every owed result has been taken, then lets
    // the block finish any trailing microcode steps.
    task automatic drain_results();
        req_ch.valid <= 1'b0;
        do @(posedge i_clk); while (pending != 0);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    initial begin
        int pick;
        int rd_left;
        int wr_left;
        int n_rd;
        int n_wr;
        int k;

        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.req_type  = RQ_START_READ;
        req_ch.thread_id = '0;
        res_ch.ready     = 1'b0;
        pace             = 0;
        sent             = 0;

        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed opening. Misuse first: releases with nothing held.
        send_request(RQ_END_READ,  4'd0);
        send_request(RQ_END_WRITE, 4'd15);
        // Two readers share the lock; a writer must wait until the last one leaves.
        send_request(RQ_START_READ,  4'd0);
        send_request(RQ_START_READ,  4'd15);
        send_request(RQ_START_WRITE, 4'd5);
        send_request(RQ_END_READ,    4'd0);
        send_request(RQ_END_READ,    4'd15);
        // With a writer holding the lock, readers and a writer queue up. On
        // release the readers win (reader preference) and are woken as a chain.
        send_request(RQ_START_READ,  4'd3);
        send_request(RQ_START_READ,  4'd12);
        send_request(RQ_START_WRITE, 4'd9);
        send_request(RQ_END_WRITE,   4'd5);
        send_request(RQ_END_READ,    4'd3);
        send_request(RQ_END_READ,    4'd12);
        send_request(RQ_END_WRITE,   4'd9);
        // Writer to writer hand-over when no reader waits.
        send_request(RQ_START_WRITE, 4'd10);
        send_request(RQ_START_WRITE, 4'd6);
        send_request(RQ_END_WRITE,   4'd10);
        send_request(RQ_END_WRITE,   4'd6);
        // An end read while a writer holds the lock is still misuse.
        send_request(RQ_START_WRITE, 4'd0);
        send_request(RQ_END_READ,    4'd11);
        send_request(RQ_START_WRITE, 4'd7);
        send_request(RQ_END_WRITE,   4'd0);
        send_request(RQ_END_WRITE,   4'd7);
        drain_results();

        // Random part: mostly well-formed lock sessions with random thread ids,
        // some of them large enough to fill a wait queue or the reader count,
        // with stray requests mixed in.
        while (sent < RUN_ITEMS) begin
            pick = $urandom_range(7);
            case (pick)
                0, 1, 2: begin
                    // A writer holds the lock while readers and writers pile up
                    // behind it; a queue of sixteen then overflows.
                    n_rd = $urandom_range(1) ? $urandom_range(15, 17) : $urandom_range(0, 4);
                    n_wr = $urandom_range(1) ? $urandom_range(15, 17) : $urandom_range(0, 3);
                    send_request(RQ_START_WRITE, any_tid());
                    rd_left = n_rd;
                    wr_left = n_wr;
                    while (rd_left + wr_left > 0) begin
                        if (wr_left == 0 || (rd_left > 0 && $urandom_range(1))) begin
                            send_request(RQ_START_READ, any_tid());
                            rd_left--;
                        end else begin
                            send_request(RQ_START_WRITE, any_tid());
                            wr_left--;
                        end
                    end
                    // Release wakes every queued reader; the last of them to
                    // leave hands over to the writers one at a time.
                    send_request(RQ_END_WRITE, any_tid());
                    for (k = 0; k < n_rd && k < MAX_THREADS; k++)
                        send_request(RQ_END_READ, any_tid());
                    for (k = 0; k < n_wr && k < MAX_THREADS; k++)
                        send_request(RQ_END_WRITE, any_tid());
                end
                3, 4: begin
                    // A flood of readers; the larger ones run past the reader
                    // count limit and then release more often than they held.
                    n_rd = ($urandom_range(3) == 0) ? $urandom_range(29, 34)
                                                    : $urandom_range(1, 8);
                    for (k = 0; k < n_rd; k++)
                        send_request(RQ_START_READ, any_tid());
                    for (k = 0; k < n_rd; k++)
                        send_request(RQ_END_READ, any_tid());
                end
                5, 6: begin
                    // Readers hold the lock, a writer waits, and later readers
                    // still get straight in ahead of it.
                    n_rd = $urandom_range(1, 4);
                    n_wr = $urandom_range(0, 3);
                    for (k = 0; k < n_rd; k++)
                        send_request(RQ_START_READ, any_tid());
                    send_request(RQ_START_WRITE, any_tid());
                    for (k = 0; k < n_wr; k++)
                        send_request(RQ_START_READ, any_tid());
                    for (k = 0; k < n_rd + n_wr; k++)
                        send_request(RQ_END_READ, any_tid());
                    send_request(RQ_END_WRITE, any_tid());
                end
                default: begin
                    // Stray requests of any kind, which also break up sessions.
                    n_rd = $urandom_range(1, 6);
                    for (k = 0; k < n_rd; k++)
                        send_request(t_req'($urandom_range(3)), any_tid());
                end
            endcase
            if ($urandom_range(7) == 0) drain_results();
        end

        drain_results();

        $display("Summary: %0d request transactions and %0d result transactions checked,",
                 sent, checked);
        $display("covering queue overflow, reader limit, chained wake-ups and all pacing phases.");
        if (errors == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

`default_nettype wire
